// ----- src/rfa_pkg.sv -----
// ----------------------------------------------------------------------------
// rfa_pkg
// Shared types and constants for the rational fraction ALU.
// ----------------------------------------------------------------------------
package rfa_pkg;

	typedef enum logic [3:0] {
		ACT_NORM = 4'd0,
		ACT_ADD  = 4'd1,
		ACT_SUB  = 4'd2,
		ACT_MUL  = 4'd3,
		ACT_DIV  = 4'd4,
		ACT_NEG  = 4'd5,
		ACT_CMP  = 4'd6,
		ACT_INT  = 4'd7,
		ACT_NZ   = 4'd8
	} action_t;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_ZDEN = 2'd1;
	localparam logic [1:0] ST_DIVZ = 2'd2;
	localparam logic [1:0] ST_OVF  = 2'd3;

	localparam int MagW = 64;

	typedef enum logic [3:0] {
		OP_LOAD,     // latch operands, decode
		OP_MUL1,     // first product -> p
		OP_MUL2,     // second product -> q
		OP_MUL3,     // den product -> d
		OP_COMBINE,  // form numerator from p,q
		OP_DIVSTART, // start divider on x / y (|an| / |ad| for to-integer)
		OP_DIVSTEP,  // one restoring step
		OP_GCDNEXT,  // x <= y, y <= rem
		OP_REDSETUP, // setup nm / g
		OP_REDNUM,   // latch nm/g, setup dm / g
		OP_REDDEN,   // latch dm/g
		OP_FINISH,   // drive result
		OP_NONE
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic y_zero;
		logic need_mul;
		logic need_gcd;
		logic is_cmp_int;
		logic early;
	} status_t;

endpackage

// ----- src/rational_fraction_alu_top.sv -----
// Flow: status errors and unused codes go straight to done; compare forms products;
// to-integer runs one division; normalize/negate run the Euclid gcd loop on the divider,
// add/sub/mul/div form products first, and both reduce numerator and denominator by the gcd.
// Throughput: one request at a time; busy falls in the cycle done pulses.
// Reset: arst_n asynchronous, clears the sequencer to idle; results go out on
// done for one cycle and the receiver cannot stall.
// ----------------------------------------------------------------------------
// rational_fraction_alu_top
// Rational fraction ALU with gcd reduction.
// ----------------------------------------------------------------------------
module rational_fraction_alu_top #(
	parameter int DATA_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	output logic        done,
	input  logic [3:0]  action,
	input  logic [31:0] a_num,
	input  logic [31:0] a_den,
	input  logic [31:0] b_num,
	input  logic [31:0] b_den,
	output logic [31:0] res_num,
	output logic [30:0] res_den,
	output logic        less,
	output logic        equal,
	output logic        nonzero,
	output logic [1:0]  status
);
	rfa_pkg::cmd_t    cmd;
	rfa_pkg::status_t stat;
	logic             busy_i;

	// capture inputs in the idle cycle they are accepted
	logic [3:0]  act_q;
	logic [31:0] an_q, ad_q, bn_q, bd_q;
	always_ff @(posedge clk) begin
		if (start && !busy_i) begin
			act_q <= action;
			an_q  <= a_num;
			ad_q  <= a_den;
			bn_q  <= b_num;
			bd_q  <= b_den;
		end
	end

	rfa_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy_i),
		.done   (done),
		.cmd    (cmd),
		.stat   (stat)
	);

	rfa_datapath #(.DATA_WIDTH(DATA_WIDTH)) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.stat    (stat),
		.action  (act_q),
		.a_num   (an_q),
		.a_den   (ad_q),
		.b_num   (bn_q),
		.b_den   (bd_q),
		.res_num (res_num),
		.res_den (res_den),
		.less    (less),
		.equal   (equal),
		.nonzero (nonzero),
		.status  (status)
	);

	assign busy = busy_i;

endmodule

// ----- src/rfa_datapath.sv -----
// ----------------------------------------------------------------------------
// rfa_datapath
// Operand registers, one 32x32 multiplier, a bit-serial 64-bit divider
// shared by gcd, reduction and to-integer, and result formatting.
// ----------------------------------------------------------------------------
module rfa_datapath #(
	parameter int DATA_WIDTH = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  rfa_pkg::cmd_t       cmd,
	output rfa_pkg::status_t    stat,
	input  logic [3:0]          action,
	input  logic [31:0]         a_num,
	input  logic [31:0]         a_den,
	input  logic [31:0]         b_num,
	input  logic [31:0]         b_den,
	output logic [31:0]         res_num,
	output logic [30:0]         res_den,
	output logic                less,
	output logic                equal,
	output logic                nonzero,
	output logic [1:0]          status
);
	localparam int W = rfa_pkg::MagW;
	localparam int DW = DATA_WIDTH;

	logic [3:0]  act_q;
	logic [31:0] an_mag_q, ad_mag_q, bn_mag_q, bd_mag_q;
	logic        an_neg_q, ad_neg_q, bn_neg_q, bd_neg_q;
	logic        an_nz_q;
	logic [W-1:0] p_q, q_q, d_q, x_q, y_q, nm_q, dm_q, g_q;
	logic        sp_q, sq_q, neg_q;
	logic [W-1:0] rem_q, quo_q, dvs_q;
	logic [6:0]  cnt_q;
	logic [1:0]  st_q;
	logic [31:0] rn_q;
	logic [30:0] rd_q;
	logic        less_q, equal_q;

	function automatic logic signed [DW-1:0] trim(input logic [31:0] v);
		return v[DW-1:0];
	endfunction

	logic signed [DW-1:0] an_s, ad_s, bn_s, bd_s;
	assign an_s = trim(a_num);
	assign ad_s = trim(a_den);
	assign bn_s = trim(b_num);
	assign bd_s = trim(b_den);

	function automatic logic [31:0] magf(input logic signed [DW-1:0] v);
		logic [DW-1:0] m;
		m = v[DW-1] ? (~v + 1'b1) : v;
		return 32'(m);
	endfunction

	// multiplier operand select
	logic [31:0] ma, mb;
	logic [63:0] prod;
	always_comb begin
		ma = an_mag_q;
		mb = bd_mag_q;
		case (cmd)
			rfa_pkg::OP_MUL1: begin
				ma = an_mag_q;
				mb = (act_q == rfa_pkg::ACT_MUL) ? bn_mag_q : bd_mag_q;
			end
			rfa_pkg::OP_MUL2: begin
				ma = bn_mag_q;
				mb = ad_mag_q;
			end
			rfa_pkg::OP_MUL3: begin
				ma = ad_mag_q;
				mb = (act_q == rfa_pkg::ACT_DIV) ? bn_mag_q : bd_mag_q;
			end
			default: begin
				ma = an_mag_q;
				mb = bd_mag_q;
			end
		endcase
	end
	assign prod = 64'(ma) * 64'(mb);

	// one restoring division step
	logic [W:0]   rem_sh;
	logic [W:0]   rem_try;
	assign rem_sh  = {rem_q, quo_q[W-1]};
	assign rem_try = rem_sh - {1'b0, dvs_q};

	logic [W-1:0] lim;
	assign lim = 64'd1 << (DW - 1);

	// signed compare on sign-magnitude products
	logic lhs_neg, rhs_neg, lhs_lt, lhs_eq;
	always_comb begin
		lhs_neg = sp_q && (p_q != '0);
		rhs_neg = sq_q && (q_q != '0);
		lhs_eq  = (lhs_neg == rhs_neg) && (p_q == q_q);
		if (lhs_neg != rhs_neg)
			lhs_lt = lhs_neg;
		else if (lhs_neg)
			lhs_lt = p_q > q_q;
		else
			lhs_lt = p_q < q_q;
	end

	always_comb begin
		stat.div_done   = (cnt_q == 7'd0);
		stat.y_zero     = (y_q == '0);
		stat.need_mul   = (act_q == rfa_pkg::ACT_ADD) || (act_q == rfa_pkg::ACT_SUB) ||
			(act_q == rfa_pkg::ACT_MUL) || (act_q == rfa_pkg::ACT_DIV) ||
			(act_q == rfa_pkg::ACT_CMP);
		stat.need_gcd   = (act_q == rfa_pkg::ACT_NORM) || (act_q == rfa_pkg::ACT_NEG) ||
			(act_q == rfa_pkg::ACT_ADD) || (act_q == rfa_pkg::ACT_SUB) ||
			(act_q == rfa_pkg::ACT_MUL) || (act_q == rfa_pkg::ACT_DIV);
		stat.is_cmp_int = (act_q == rfa_pkg::ACT_CMP) || (act_q == rfa_pkg::ACT_INT);
		stat.early      = (st_q != rfa_pkg::ST_OK) || (act_q > rfa_pkg::ACT_INT) ||
			(act_q == rfa_pkg::ACT_CMP && 1'b0);
	end

	logic [W-1:0] nm_red, dm_red;
	logic         neg_fin;
	logic [1:0]   st_fin;
	logic [31:0]  rn_fin;
	logic [30:0]  rd_fin;
	logic         q_neg;
	logic [W-1:0] qmag;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= rfa_pkg::ST_OK;
			cnt_q   <= '0;
			less_q  <= 1'b0;
			equal_q <= 1'b0;
		end else begin
			case (cmd)
				rfa_pkg::OP_LOAD: begin
					act_q    <= action;
					an_mag_q <= magf(an_s);
					ad_mag_q <= magf(ad_s);
					bn_mag_q <= magf(bn_s);
					bd_mag_q <= magf(bd_s);
					an_neg_q <= an_s[DW-1];
					ad_neg_q <= ad_s[DW-1];
					bn_neg_q <= bn_s[DW-1];
					bd_neg_q <= bd_s[DW-1];
					an_nz_q  <= (an_s != '0);
					less_q   <= 1'b0;
					equal_q  <= 1'b0;
					cnt_q    <= '0;
					if (((action <= 4'(rfa_pkg::ACT_INT)) && ad_s == '0) ||
						(((action >= 4'(rfa_pkg::ACT_ADD) && action <= 4'(rfa_pkg::ACT_DIV)) ||
						action == 4'(rfa_pkg::ACT_CMP)) && bd_s == '0))
						st_q <= rfa_pkg::ST_ZDEN;
					else if (action == 4'(rfa_pkg::ACT_DIV) && bn_s == '0)
						st_q <= rfa_pkg::ST_DIVZ;
					else
						st_q <= rfa_pkg::ST_OK;
					// single-operand setups
					x_q   <= W'(magf(an_s));
					y_q   <= W'(magf(ad_s));
					nm_q  <= W'(magf(an_s));
					dm_q  <= W'(magf(ad_s));
					neg_q <= (an_s[DW-1] != ad_s[DW-1]) ^ (action == 4'(rfa_pkg::ACT_NEG));
				end
				rfa_pkg::OP_MUL1: begin
					p_q  <= prod;
					sp_q <= (act_q == rfa_pkg::ACT_MUL) ?
						(an_neg_q != bn_neg_q) : (an_neg_q != bd_neg_q);
				end
				rfa_pkg::OP_MUL2: begin
					q_q  <= prod;
					sq_q <= (bn_neg_q != ad_neg_q) ^ (act_q == rfa_pkg::ACT_SUB);
				end
				rfa_pkg::OP_MUL3: begin
					d_q <= prod;
				end
				rfa_pkg::OP_COMBINE: begin
					case (act_q)
						rfa_pkg::ACT_ADD, rfa_pkg::ACT_SUB: begin
							if (sp_q == sq_q) begin
								nm_q  <= p_q + q_q;
								neg_q <= sp_q != (ad_neg_q != bd_neg_q);
							end else if (p_q >= q_q) begin
								nm_q  <= p_q - q_q;
								neg_q <= sp_q != (ad_neg_q != bd_neg_q);
							end else begin
								nm_q  <= q_q - p_q;
								neg_q <= sq_q != (ad_neg_q != bd_neg_q);
							end
							x_q  <= (sp_q == sq_q) ? p_q + q_q :
								((p_q >= q_q) ? p_q - q_q : q_q - p_q);
							dm_q <= d_q;
							y_q  <= d_q;
						end
						rfa_pkg::ACT_MUL: begin
							nm_q  <= p_q;
							x_q   <= p_q;
							dm_q  <= d_q;
							y_q   <= d_q;
							neg_q <= (an_neg_q != bn_neg_q) != (ad_neg_q != bd_neg_q);
						end
						rfa_pkg::ACT_DIV: begin
							nm_q  <= p_q;
							x_q   <= p_q;
							dm_q  <= d_q;
							y_q   <= d_q;
							neg_q <= (an_neg_q != bd_neg_q) != (ad_neg_q != bn_neg_q);
						end
						rfa_pkg::ACT_CMP: begin
							// lhs = an*bd (p, sp), rhs = bn*ad (q, sq)
							equal_q <= lhs_eq;
							less_q  <= (ad_neg_q != bd_neg_q) ? (!lhs_lt && !lhs_eq) : lhs_lt;
						end
						default: begin
						end
					endcase
				end
				rfa_pkg::OP_DIVSTART: begin
					// to-integer divides |an| by |ad|; gcd divides x by y
					if (act_q == rfa_pkg::ACT_INT) begin
						quo_q <= W'(an_mag_q);
						dvs_q <= W'(ad_mag_q);
					end else begin
						quo_q <= x_q;
						dvs_q <= y_q;
					end
					rem_q <= '0;
					cnt_q <= 7'(W);
				end
				rfa_pkg::OP_DIVSTEP: begin
					if (!rem_try[W]) begin
						rem_q <= rem_try[W-1:0];
						quo_q <= {quo_q[W-2:0], 1'b1};
					end else begin
						rem_q <= rem_sh[W-1:0];
						quo_q <= {quo_q[W-2:0], 1'b0};
					end
					cnt_q <= cnt_q - 7'd1;
				end
				rfa_pkg::OP_GCDNEXT: begin
					x_q <= y_q;
					y_q <= rem_q;
				end
				rfa_pkg::OP_REDSETUP: begin
					g_q   <= x_q;
					quo_q <= nm_q;
					dvs_q <= x_q;
					rem_q <= '0;
					cnt_q <= 7'(W);
				end
				rfa_pkg::OP_REDNUM: begin
					nm_q  <= quo_q;
					quo_q <= dm_q;
					dvs_q <= g_q;
					rem_q <= '0;
					cnt_q <= 7'(W);
				end
				rfa_pkg::OP_REDDEN: begin
					dm_q <= quo_q;
				end
				rfa_pkg::OP_FINISH: begin
					st_q <= st_fin;
					if (st_fin != rfa_pkg::ST_OK || act_q != rfa_pkg::ACT_CMP) begin
						less_q  <= 1'b0;
						equal_q <= 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// result formatting from reduced values
	always_comb begin
		nm_red  = nm_q;
		dm_red  = dm_q;
		neg_fin = neg_q && (nm_red != '0);
		st_fin  = st_q;
		rn_fin  = '0;
		rd_fin  = 31'd1;
		q_neg   = an_neg_q != ad_neg_q;
		qmag    = quo_q;
		if (st_q == rfa_pkg::ST_OK) begin
			case (act_q)
				rfa_pkg::ACT_NORM, rfa_pkg::ACT_NEG, rfa_pkg::ACT_ADD,
				rfa_pkg::ACT_SUB, rfa_pkg::ACT_MUL, rfa_pkg::ACT_DIV: begin
					if (dm_red > lim - 64'd1 || nm_red > (neg_fin ? lim : lim - 64'd1))
						st_fin = rfa_pkg::ST_OVF;
					else begin
						rn_fin = neg_fin ? 32'(64'd0 - nm_red) : 32'(nm_red);
						rd_fin = 31'(dm_red);
					end
				end
				rfa_pkg::ACT_INT: begin
					if (qmag > (q_neg ? lim : lim - 64'd1))
						st_fin = rfa_pkg::ST_OVF;
					else
						rn_fin = q_neg ? 32'(64'd0 - qmag) : 32'(qmag);
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rn_q <= '0;
			rd_q <= 31'd1;
		end else if (cmd == rfa_pkg::OP_FINISH) begin
			rn_q <= rn_fin;
			rd_q <= rd_fin;
		end
	end

	assign res_num = rn_q;
	assign res_den = rd_q;
	assign less    = less_q;
	assign equal   = equal_q;
	assign nonzero = an_nz_q;
	assign status  = st_q;

endmodule

// ----- src/rfa_ctrl.sv -----
// ----------------------------------------------------------------------------
// rfa_ctrl
// Sequencer: products, gcd loop, reduction divisions, result strobe.
// ----------------------------------------------------------------------------
module rfa_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	output logic             done,
	output rfa_pkg::cmd_t    cmd,
	input  rfa_pkg::status_t stat
);
	typedef enum logic [3:0] {
		S_IDLE, S_LOAD, S_M1, S_M2, S_M3, S_COMB, S_GTEST, S_GDIV, S_GNEXT,
		S_RSET, S_RDIV1, S_RNUM, S_RDIV2, S_RDEN, S_IDIV, S_FIN
	} state_t;

	state_t state_q;
	logic   done_q;

	always_comb begin
		case (state_q)
			S_LOAD:  cmd = rfa_pkg::OP_LOAD;
			S_M1:    cmd = rfa_pkg::OP_MUL1;
			S_M2:    cmd = rfa_pkg::OP_MUL2;
			S_M3:    cmd = rfa_pkg::OP_MUL3;
			// to integer starts its divider here
			S_COMB:  cmd = (stat.is_cmp_int && !stat.need_mul) ?
				rfa_pkg::OP_DIVSTART : rfa_pkg::OP_COMBINE;
			S_GTEST: cmd = stat.y_zero ? rfa_pkg::OP_NONE : rfa_pkg::OP_DIVSTART;
			S_GDIV:  cmd = stat.div_done ? rfa_pkg::OP_NONE : rfa_pkg::OP_DIVSTEP;
			S_GNEXT: cmd = rfa_pkg::OP_GCDNEXT;
			S_RSET:  cmd = rfa_pkg::OP_REDSETUP;
			S_RDIV1: cmd = stat.div_done ? rfa_pkg::OP_NONE : rfa_pkg::OP_DIVSTEP;
			S_RNUM:  cmd = rfa_pkg::OP_REDNUM;
			S_RDIV2: cmd = stat.div_done ? rfa_pkg::OP_NONE : rfa_pkg::OP_DIVSTEP;
			S_RDEN:  cmd = rfa_pkg::OP_REDDEN;
			S_IDIV:  cmd = stat.div_done ? rfa_pkg::OP_NONE : rfa_pkg::OP_DIVSTEP;
			S_FIN:   cmd = rfa_pkg::OP_FINISH;
			default: cmd = rfa_pkg::OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: if (start) state_q <= S_LOAD;
				S_LOAD: state_q <= S_M1;
				S_M1: begin
					if (stat.early) state_q <= S_FIN;
					else if (stat.need_mul) state_q <= S_M2;
					else if (stat.need_gcd) state_q <= S_GTEST;
					else state_q <= S_COMB; // to integer: start divider via COMB path
				end
				S_M2: state_q <= S_M3;
				S_M3: state_q <= S_COMB;
				S_COMB: begin
					if (stat.need_gcd) state_q <= S_GTEST;
					else if (stat.is_cmp_int && !stat.need_mul) state_q <= S_IDIV;
					else state_q <= S_FIN;
				end
				S_GTEST: state_q <= stat.y_zero ? S_RSET : S_GDIV;
				S_GDIV:  if (stat.div_done) state_q <= S_GNEXT;
				S_GNEXT: state_q <= S_GTEST;
				S_RSET:  state_q <= S_RDIV1;
				S_RDIV1: if (stat.div_done) state_q <= S_RNUM;
				S_RNUM:  state_q <= S_RDIV2;
				S_RDIV2: if (stat.div_done) state_q <= S_RDEN;
				S_RDEN:  state_q <= S_FIN;
				S_IDIV:  if (stat.div_done) state_q <= S_FIN;
				S_FIN: begin
					state_q <= S_IDLE;
					done_q  <= 1'b1;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

endmodule
